/* rtl/lpht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Default table size
    localparam int TABLE_SLOTS_DEF = 32;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int MARK_W   = 2;

    // Requested operations
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    // One slot entry as stored in the slot RAM
    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [KEY_W-1:0]  key;
    } t_slot;

endpackage

`default_nettype wire

/* rtl/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash table with linear probing over TABLE_SLOTS slots held in
// one RAM (key plus 2-bit mark per slot). After reset the block runs a clearing
// pass over every slot with o_ready low before it takes the first item.
// An item (insert, search, remove) is accepted, its key is reduced modulo
// TABLE_SLOTS (reciprocal multiply, then one compare and subtract), each probed
// slot is read from the RAM and then checked, and the result is presented and
// held until i_ready. A request probes between 1 and TABLE_SLOTS slots; an
// unknown action skips the modulo and the probe and answers "not found".
// One item is in flight at a time: o_ready is high only when the block is idle
// and no result is waiting.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [lpht_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [lpht_pkg::KEY_W-1:0]      i_key,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [lpht_pkg::STATUS_W-1:0]   o_status,
    output logic      [lpht_pkg::SLOT_W-1:0]     o_slot_index
);

    localparam int IW     = $clog2(TABLE_SLOTS);
    localparam int SLOT_E = $bits(lpht_pkg::t_slot);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                        r_state, n_state;
    logic [IW-1:0]                     r_idx, n_idx;
    logic [IW-1:0]                     r_home, n_home;
    logic [lpht_pkg::ACTION_W-1:0]     r_action, n_action;
    logic [lpht_pkg::KEY_W-1:0]        r_key, n_key;
    logic [lpht_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [IW-1:0]                     r_out_idx, n_out_idx;

    logic                              w_accept;
    logic                              w_mod_start;
    logic                              w_mod_done;
    logic [IW-1:0]                     w_mod_rem;
    logic                              w_we;
    logic                              w_re;
    lpht_pkg::t_slot                   w_wslot;
    lpht_pkg::t_slot                   w_rslot;
    logic [SLOT_E-1:0]                 w_rdata;
    logic [IW-1:0]                     w_idx_nxt;
    logic                              w_match;
    logic [IW+lpht_pkg::SLOT_W-1:0]    w_idx_ext;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign w_accept = i_valid && o_ready;

    // Home slot computation
    lpht_mod_unit #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_key   (i_key),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // Slot store
    lpht_ram #(
        .WIDTH (SLOT_E),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wslot),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rslot   = w_rdata;
    assign w_re      = (r_state == S_READ);
    assign w_idx_nxt = (r_idx == LAST_IDX) ? '0 : (r_idx + 1'b1);
    assign w_match   = (w_rslot.mark == lpht_pkg::MARK_USED) && (w_rslot.key == r_key);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_home      = r_home;
        n_action    = r_action;
        n_key       = r_key;
        n_status    = r_status;
        n_out_idx   = r_out_idx;
        w_mod_start = 1'b0;
        w_we        = 1'b0;
        w_wslot     = '{mark: lpht_pkg::MARK_EMPTY, key: '0};
        unique case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = w_idx_nxt;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_action = i_action;
                    n_key    = i_key;
                    case (i_action)
                        lpht_pkg::ACT_INSERT, lpht_pkg::ACT_SEARCH,
                        lpht_pkg::ACT_REMOVE: begin
                            w_mod_start = 1'b1;
                            n_state     = S_MOD;
                        end
                        default: begin
                            n_status  = lpht_pkg::ST_MISSING;
                            n_out_idx = '0;
                            n_state   = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_home  = w_mod_rem;
                    n_idx   = w_mod_rem;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_rslot.mark == lpht_pkg::MARK_EMPTY) begin
                    // Probe chain ends here
                    if (r_action == lpht_pkg::ACT_INSERT) begin
                        w_we      = 1'b1;
                        w_wslot   = '{mark: lpht_pkg::MARK_USED, key: r_key};
                        n_status  = lpht_pkg::ST_OK;
                        n_out_idx = r_idx;
                    end else begin
                        n_status  = lpht_pkg::ST_MISSING;
                        n_out_idx = '0;
                    end
                    n_state = S_DONE;
                end else if (w_match && (r_action != lpht_pkg::ACT_INSERT)) begin
                    // Found; remove leaves a tombstone
                    if (r_action == lpht_pkg::ACT_REMOVE) begin
                        w_we    = 1'b1;
                        w_wslot = '{mark: lpht_pkg::MARK_DELETED, key: r_key};
                    end
                    n_status  = lpht_pkg::ST_OK;
                    n_out_idx = r_idx;
                    n_state   = S_DONE;
                end else if (w_idx_nxt == r_home) begin
                    // Full wrap
                    n_status  = (r_action == lpht_pkg::ACT_INSERT) ?
                                lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
                    n_out_idx = '0;
                    n_state   = S_DONE;
                end else begin
                    n_idx   = w_idx_nxt;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_home    <= n_home;
        r_action  <= n_action;
        r_key     <= n_key;
        r_status  <= n_status;
        r_out_idx <= n_out_idx;
    end

    // Result port: low bits of the slot number
    assign w_idx_ext    = {{lpht_pkg::SLOT_W{1'b0}}, r_out_idx};
    assign o_status     = r_status;
    assign o_slot_index = w_idx_ext[lpht_pkg::SLOT_W-1:0];

    // Failed requests report slot zero
    a_fail_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != lpht_pkg::ST_OK)) |-> (o_slot_index == '0))
        else $error("nonzero slot index on failed request");

    // Probe index stays inside the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("probe index out of range");

    // Unknown action answers not found on the next cycle
    a_bad_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action != lpht_pkg::ACT_INSERT) &&
         (i_action != lpht_pkg::ACT_SEARCH) && (i_action != lpht_pkg::ACT_REMOVE))
        |=> (o_valid && (o_status == lpht_pkg::ST_MISSING)))
        else $error("unknown action not answered as missing");

    // Table full is only ever an insert result
    a_full_insert_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == lpht_pkg::ST_FULL)) |-> (r_action == lpht_pkg::ACT_INSERT))
        else $error("table full on a non-insert request");

endmodule

`default_nettype wire

/* rtl/lpht_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lpht_mod_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Key modulo TABLE_SLOTS by reciprocal multiplication, in registered steps:
// estimate the quotient (it may come out one low), take the low bits of
// key minus quotient times slots, then one compare and subtract.
module lpht_mod_unit #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [lpht_pkg::KEY_W-1:0]     i_key,
    output logic                                o_done,
    output logic      [$clog2(TABLE_SLOTS)-1:0] o_rem
);

    localparam int KW = lpht_pkg::KEY_W;
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam logic [IW:0]   SLOTS_L = (IW + 1)'(TABLE_SLOTS);
    localparam logic [KW-1:0] RECIP   = KW'((64'd1 << KW) / TABLE_SLOTS);

    logic            r_v1, n_v1;
    logic            r_v2, n_v2;
    logic            r_done, n_done;
    logic [IW:0]     r_quo, n_quo;
    logic [IW:0]     r_klo, n_klo;
    logic [IW:0]     r_part, n_part;
    logic [IW-1:0]   r_rem, n_rem;
    logic [2*KW-1:0] w_prod;
    logic [IW:0]     w_qn;
    logic [IW:0]     w_red;

    // Quotient estimate: key times floor(2^KEY_W / slots), upper half
    assign w_prod = {{KW{1'b0}}, i_key} * {{KW{1'b0}}, RECIP};

    // Only the low bits matter: the true difference is below 2 * slots
    assign w_qn  = r_quo * SLOTS_L;
    assign w_red = (r_part >= SLOTS_L) ? (r_part - SLOTS_L) : r_part;

    always_comb begin
        n_v1   = i_start;
        n_v2   = r_v1;
        n_done = r_v2;
        n_quo  = r_quo;
        n_klo  = r_klo;
        n_part = r_part;
        n_rem  = r_rem;
        if (i_start) begin
            n_quo = w_prod[KW+IW:KW];
            n_klo = i_key[IW:0];
        end
        if (r_v1) begin
            n_part = r_klo - w_qn;
        end
        if (r_v2) begin
            n_rem = w_red[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= n_v1;
            r_v2   <= n_v2;
            r_done <= n_done;
        end
        r_quo  <= n_quo;
        r_klo  <= n_klo;
        r_part <= n_part;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    // Remainder in range once finished
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ({1'b0, r_rem} < SLOTS_L))
        else $error("remainder out of range");

    // Done pulses only at the end of the pipeline
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_v2))
        else $error("done without a running reduction");

    // Never restarted mid-run
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> !i_start)
        else $error("start while busy");

endmodule

`default_nettype wire

/* verif/linear_probe_hash_table_test.sv */
`timescale 1ns / 1ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int TABLE_SLOTS  = TABLE_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 100;
    localparam int MAX_PRINTED  = 40;

    // Action code the block does not know; answered as not found
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    // Tracks the slot store and queues the answer each request should get
    class slot_table_tracker;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [SLOT_W-1:0]   slot;
        } slot_answer;

        logic [KEY_W-1:0]  key_of  [TABLE_SLOTS];
        logic [MARK_W-1:0] mark_of [TABLE_SLOTS];
        slot_answer        pending_answers [$];
        int                n_action [4];
        int                n_status [4];
        int                n_checked;

        function new();
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                key_of[s]  = '0;
                mark_of[s] = MARK_EMPTY;
            end
            for (int c = 0; c < 4; c++) begin
                n_action[c] = 0;
                n_status[c] = 0;
            end
            n_checked = 0;
        endfunction

        // Probe from home until an empty slot or a full turn
        function bit locate(input logic [KEY_W-1:0] key, output int where);
            int home;
            int pos;
            home  = int'(key % TABLE_SLOTS);
            pos   = home;
            where = 0;
            do begin
                if (mark_of[pos] == MARK_EMPTY)
                    return 1'b0;
                if (mark_of[pos] == MARK_USED && key_of[pos] == key) begin
                    where = pos;
                    return 1'b1;
                end
                pos = (pos + 1) % TABLE_SLOTS;
            end while (pos != home);
            return 1'b0;
        endfunction

        function void note_request(input logic [ACTION_W-1:0] act,
                                   input logic [KEY_W-1:0] key);
            slot_answer ans;
            int         pos;
            int         home;
            bit         full;
            ans.status = ST_MISSING;
            ans.slot   = '0;
            case (act)
                ACT_INSERT: begin
                    // first never-used slot; tombstones are skipped
                    home = int'(key % TABLE_SLOTS);
                    pos  = home;
                    full = 1'b0;
                    while (mark_of[pos] != MARK_EMPTY && !full) begin
                        pos = (pos + 1) % TABLE_SLOTS;
                        if (pos == home)
                            full = 1'b1;
                    end
                    if (full) begin
                        ans.status = ST_FULL;
                    end else begin
                        key_of[pos]  = key;
                        mark_of[pos] = MARK_USED;
                        ans.status   = ST_OK;
                        ans.slot     = SLOT_W'(pos);
                    end
                end
                ACT_SEARCH: begin
                    if (locate(key, pos)) begin
                        ans.status = ST_OK;
                        ans.slot   = SLOT_W'(pos);
                    end
                end
                ACT_REMOVE: begin
                    if (locate(key, pos)) begin
                        mark_of[pos] = MARK_DELETED;
                        ans.status   = ST_OK;
                        ans.slot     = SLOT_W'(pos);
                    end
                end
                default: ;
            endcase
            n_action[act]++;
            n_status[ans.status]++;
            pending_answers.push_back(ans);
        endfunction

        // Empty string when the result matches the oldest expected answer
        function string check_answer(input logic [STATUS_W-1:0] status,
                                     input logic [SLOT_W-1:0] slot);
            slot_answer want;
            string      msg;
            if (pending_answers.size() == 0)
                return $sformatf("unexpected result: status %0d slot %0d", status, slot);
            want = pending_answers.pop_front();
            n_checked++;
            msg = "";
            if (status !== want.status)
                msg = {msg, $sformatf(" status %0d want %0d", status, want.status)};
            if (slot !== want.slot)
                msg = {msg, $sformatf(" slot %0d want %0d", slot, want.slot)};
            if (msg != "")
                msg = {$sformatf("result %0d:", n_checked), msg};
            return msg;
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic [ACTION_W-1:0] i_action     = ACT_INSERT;
    logic [KEY_W-1:0]    i_key        = '0;
    logic                i_ready      = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_index;

    slot_table_tracker table_tracker;
    int                mismatches = 0;
    bit                calm       = 1'b0;
    logic [KEY_W-1:0]  key_pool [$];

    linear_probe_hash_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_slot_index(o_slot_index)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("[linear_probe_hash_table] ERROR");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Present one item and hold it until accepted
    task automatic offer_request(input logic [ACTION_W-1:0] act,
                                 input logic [KEY_W-1:0] key);
        i_valid  <= 1'b1;
        i_action <= act;
        i_key    <= key;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        table_tracker.note_request(act, key);
    endtask

    // Random gap on the sender side
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key);
        offer_request(act, key);
        sender_gap();
    endtask

    // Result side: check, random stalls, one long hold-off
    initial begin : result_sink
        int    stall_left;
        bit    held;
        string msg;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                msg = table_tracker.check_answer(o_status, o_slot_index);
                if (msg != "")
                    report_mismatch(msg);
            end
            if (!held && table_tracker.n_checked == HOLD_AFTER) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 12) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int               pick;
        logic [KEY_W-1:0] key;
        table_tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, collisions, wrap, tombstones, duplicates
        send(ACT_SEARCH, 31'd5);            // empty table
        send(ACT_REMOVE, 31'd5);            // remove of missing key
        send(ACT_INSERT, 31'd1);            // smallest key
        send(ACT_INSERT, 31'h7FFF_FFFF);    // largest key, home 31
        send(ACT_INSERT, 31'd33);           // collides with 1
        send(ACT_INSERT, 31'd0);            // key zero
        send(ACT_INSERT, 31'd63);           // home 31, probe wraps
        send(ACT_SEARCH, 31'd33);
        send(ACT_SEARCH, 31'd0);
        send(ACT_SEARCH, 31'd63);
        send(ACT_REMOVE, 31'd1);            // leaves a tombstone
        send(ACT_SEARCH, 31'd33);           // past the tombstone
        send(ACT_INSERT, 31'd65);           // tombstone not reused
        send(ACT_REMOVE, 31'd1);            // already removed
        send(ACT_INSERT, 31'd33);           // duplicate key
        send(ACT_SEARCH, 31'd33);           // finds the first copy
        send(ACT_UNKNOWN, 31'd33);          // unknown action
        send(ACT_SEARCH, 31'h7FFF_FFFF);
        send(ACT_REMOVE, 31'd0);
        send(ACT_SEARCH, 31'd97);           // miss ends at empty slot
        send(ACT_UNKNOWN, 31'h7FFF_FFFF);
        key_pool = '{31'd33, 31'd63, 31'd65, 31'h7FFF_FFFF};

        // random: mostly requests on keys already inserted
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(0, 99);
            key  = KEY_W'($urandom);
            if (pick < 12) begin
                if ($urandom_range(0, 3) == 0 && key_pool.size() > 0)
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                key_pool.push_back(key);
                send(ACT_INSERT, key);
            end else if (pick < 52) begin
                send(ACT_SEARCH, key_pool[$urandom_range(0, key_pool.size() - 1)]);
            end else if (pick < 75) begin
                send(ACT_REMOVE, key_pool[$urandom_range(0, key_pool.size() - 1)]);
            end else if (pick < 95) begin
                send($urandom_range(0, 1) ? ACT_SEARCH : ACT_REMOVE, key);
            end else begin
                send(ACT_UNKNOWN, key);
            end
        end
        i_valid <= 1'b0;

        // drain
        while (table_tracker.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d insert, %0d search, %0d remove, %0d unknown action",
                 table_tracker.n_action[ACT_INSERT], table_tracker.n_action[ACT_SEARCH],
                 table_tracker.n_action[ACT_REMOVE], table_tracker.n_action[ACT_UNKNOWN]);
        $display("answers: %0d done, %0d table full, %0d not found; %0d mismatches",
                 table_tracker.n_status[ST_OK], table_tracker.n_status[ST_FULL],
                 table_tracker.n_status[ST_MISSING], mismatches);
        if (mismatches == 0) begin
            $display("[linear_probe_hash_table] OK");
        end else begin
            $display("[linear_probe_hash_table] ERROR");
        end
        $finish;
    end

endmodule
